[rtl/core/vector_autocorrelation_top_assert.svh]
// assertion macros used by vector_autocorrelation_top
`ifndef VECTOR_AUTOCORRELATION_TOP_ASSERT_SVH
`define VECTOR_AUTOCORRELATION_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define VAC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vac: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define VAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vac: next-cycle check failed");

`endif

[rtl/core/vac_pkg.sv]
package vac_pkg;

	localparam int MAX_VECTORS = 128;
	localparam int COMP_WIDTH  = 24;
	localparam int FIELD_W     = 24;
	localparam int NUM_LANES   = 3;

	localparam int ADDR_W = $clog2(MAX_VECTORS);
	localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
	localparam int HALF_W = $clog2(MAX_VECTORS / 2 + 1);
	localparam int IDX_W  = (MAX_VECTORS / 2 > 1) ? $clog2(MAX_VECTORS / 2) : 1;

	localparam int PROD_W = 2 * COMP_WIDTH;
	localparam int DOT_W  = PROD_W + 2;
	localparam int SUM_W  = 64;
	localparam int LAG_W  = 6;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_GAP
	} vac_state_t;

	// travels beside the lane data through the pipeline
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last_k;
		logic             last_lag;
		logic [IDX_W-1:0] lag;
	} vac_tag_t;

endpackage

[rtl/core/vac_lane.sv]
module vac_lane (
	input  logic                                clk,
	input  logic                                we,
	input  logic [vac_pkg::ADDR_W-1:0]          waddr,
	input  logic [vac_pkg::COMP_WIDTH-1:0]      wdata,
	input  logic [vac_pkg::ADDR_W-1:0]          raddr_a,
	input  logic [vac_pkg::ADDR_W-1:0]          raddr_b,
	output logic signed [vac_pkg::PROD_W-1:0]   prod_s2
);

	logic [vac_pkg::COMP_WIDTH-1:0] mem_q [vac_pkg::MAX_VECTORS];
	logic signed [vac_pkg::COMP_WIDTH-1:0] rd_a_s1;
	logic signed [vac_pkg::COMP_WIDTH-1:0] rd_b_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// two registered read ports: element k+j and element k
	always_ff @(posedge clk) begin
		rd_a_s1 <= $signed(mem_q[raddr_a]);
		rd_b_s1 <= $signed(mem_q[raddr_b]);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
	end

endmodule

[rtl/core/vac_merge.sv]
module vac_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vac_pkg::vac_tag_t                 tag_s2,
	input  logic signed [vac_pkg::PROD_W-1:0] prod_s2 [vac_pkg::NUM_LANES],
	output vac_pkg::vac_tag_t                 tag_s4,
	output logic signed [vac_pkg::SUM_W-1:0]  acc_s4,
	output logic                              busy
);

	vac_pkg::vac_tag_t tag_s3;
	logic signed [vac_pkg::DOT_W-1:0] dot_sum;
	logic signed [vac_pkg::DOT_W-1:0] dot_s3;
	logic signed [vac_pkg::SUM_W-1:0] acc_base;

	// dot product of one vector pair from the lane products
	always_comb begin
		dot_sum = '0;
		for (int i = 0; i < vac_pkg::NUM_LANES; i++) begin
			dot_sum = dot_sum + vac_pkg::DOT_W'(prod_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dot_s3 <= dot_sum;
	end

	assign acc_base = tag_s3.first ? '0 : acc_s4;

	always_ff @(posedge clk) begin
		if (tag_s3.vld) begin
			acc_s4 <= acc_base
				+ {{(vac_pkg::SUM_W - vac_pkg::DOT_W){dot_s3[vac_pkg::DOT_W-1]}}, dot_s3};
		end
	end

	assign busy = tag_s3.vld | tag_s4.vld;

endmodule

[rtl/core/vector_autocorrelation_top.sv]
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one vector per word, tlast ends the sequence
// m_axis    out  m_axis_tvalid / m_axis_tready  one correlation value per lag, tlast on last
//
// a vector word is taken whenever s_axis_tvalid is high while loading; no results come until tlast
// after tlast with n vectors held and h = n/2, each of h lags issues h vector pairs to the shared
// three-lane dot-product pipeline, then the pipeline drains and the value is handed off;
// the input is held off during the run
// a lag starts only once the previous value has left the output register
// arst_n clears control state; the vector store has no reset and is read only where written
`include "vector_autocorrelation_top_assert.svh"

module vector_autocorrelation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// comp_x [23:0], comp_y [47:24], comp_z [71:48]
	input  logic [vac_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// lag_index [5:0], corr_sum [69:6], zero [71:70]
	output logic [vac_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,
	// overflowed [0]
	output logic                                m_axis_tuser
);

	vac_pkg::vac_state_t state_q, state_n;

	logic [vac_pkg::CNT_W-1:0]  cnt_q;
	logic                       drop_q;
	logic [vac_pkg::HALF_W-1:0] half_q;
	logic [vac_pkg::HALF_W-1:0] lag_q;
	logic [vac_pkg::IDX_W-1:0]  k_q;
	logic                       ovf_run_q;

	logic                       in_acc;
	logic                       room;
	logic [vac_pkg::CNT_W-1:0]  cnt_inc;
	logic [vac_pkg::HALF_W-1:0] half_n;
	logic                       drop_n;
	logic                       k_last;
	logic                       pipe_busy;
	logic                       merge_busy;
	logic                       res_done;
	logic                       out_take;

	logic [vac_pkg::ADDR_W-1:0] raddr_a;
	logic [vac_pkg::ADDR_W-1:0] raddr_b;
	vac_pkg::vac_tag_t          tag_issue;
	vac_pkg::vac_tag_t          tag_s1;
	vac_pkg::vac_tag_t          tag_s2;
	vac_pkg::vac_tag_t          tag_s4;
	logic signed [vac_pkg::SUM_W-1:0]  acc_s4;
	logic signed [vac_pkg::PROD_W-1:0] prod_s2 [vac_pkg::NUM_LANES];
	logic [vac_pkg::COMP_WIDTH-1:0]    comp_w [vac_pkg::NUM_LANES];

	logic                       out_vld_q;
	logic [vac_pkg::LAG_W-1:0]  out_lag_q;
	logic [vac_pkg::SUM_W-1:0]  out_sum_q;
	logic                       out_last_q;
	logic                       out_ovf_q;

	// load side
	assign s_axis_tready = (state_q == vac_pkg::ST_LOAD);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign room          = (cnt_q < vac_pkg::CNT_W'(vac_pkg::MAX_VECTORS));
	assign cnt_inc       = room ? cnt_q + vac_pkg::CNT_W'(1) : cnt_q;
	assign half_n        = vac_pkg::HALF_W'(cnt_inc >> 1);
	assign drop_n        = drop_q | (in_acc & ~room);

	for (genvar i = 0; i < vac_pkg::NUM_LANES; i++) begin : g_lane
		assign comp_w[i] = vac_pkg::COMP_WIDTH'(s_axis_tdata[i*vac_pkg::FIELD_W +: vac_pkg::FIELD_W]);

		vac_lane u_lane (
			.clk     (clk),
			.we      (in_acc & room),
			.waddr   (cnt_q[vac_pkg::ADDR_W-1:0]),
			.wdata   (comp_w[i]),
			.raddr_a (raddr_a),
			.raddr_b (raddr_b),
			.prod_s2 (prod_s2[i])
		);
	end

	// issue of one vector pair per cycle while calculating
	assign k_last  = (vac_pkg::HALF_W'(k_q) == half_q - vac_pkg::HALF_W'(1));
	assign raddr_b = vac_pkg::ADDR_W'(k_q);
	assign raddr_a = vac_pkg::ADDR_W'(k_q) + vac_pkg::ADDR_W'(lag_q);

	always_comb begin
		tag_issue.vld      = (state_q == vac_pkg::ST_CALC);
		tag_issue.first    = (k_q == '0);
		tag_issue.last_k   = k_last;
		tag_issue.last_lag = ((lag_q + vac_pkg::HALF_W'(1)) == half_q);
		tag_issue.lag      = vac_pkg::IDX_W'(lag_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_issue;
			tag_s2 <= tag_s1;
		end
	end

	vac_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s2  (tag_s2),
		.prod_s2 (prod_s2),
		.tag_s4  (tag_s4),
		.acc_s4  (acc_s4),
		.busy    (merge_busy)
	);

	assign pipe_busy = tag_s1.vld | tag_s2.vld | merge_busy;
	assign res_done  = tag_s4.vld & tag_s4.last_k;
	assign out_take  = m_axis_tvalid & m_axis_tready;

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			vac_pkg::ST_LOAD: begin
				if (in_acc && s_axis_tlast && half_n != '0) begin
					state_n = vac_pkg::ST_GAP;
				end
			end
			vac_pkg::ST_CALC: begin
				if (k_last) begin
					state_n = vac_pkg::ST_GAP;
				end
			end
			vac_pkg::ST_GAP: begin
				priority if (pipe_busy) begin
					state_n = vac_pkg::ST_GAP;
				end else if (lag_q == half_q) begin
					state_n = vac_pkg::ST_LOAD;
				end else if (!out_vld_q) begin
					state_n = vac_pkg::ST_CALC;
				end else begin
					state_n = vac_pkg::ST_GAP;
				end
			end
			default: state_n = vac_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vac_pkg::ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			half_q    <= '0;
			lag_q     <= '0;
			k_q       <= '0;
			ovf_run_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (s_axis_tlast) begin
					cnt_q     <= '0;
					drop_q    <= 1'b0;
					half_q    <= half_n;
					lag_q     <= '0;
					k_q       <= '0;
					ovf_run_q <= drop_n;
				end else begin
					cnt_q  <= cnt_inc;
					drop_q <= drop_n;
				end
			end
			if (state_q == vac_pkg::ST_CALC) begin
				if (k_last) begin
					k_q   <= '0;
					lag_q <= lag_q + vac_pkg::HALF_W'(1);
				end else begin
					k_q <= k_q + vac_pkg::IDX_W'(1);
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_done) begin
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			out_lag_q  <= vac_pkg::LAG_W'(tag_s4.lag);
			out_sum_q  <= acc_s4;
			out_last_q <= tag_s4.last_lag;
			out_ovf_q  <= ovf_run_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = vac_pkg::OUT_TDATA_W'({out_sum_q, out_lag_q});
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	`VAC_ASSERT_SAME(a_load_pipe_idle, state_q == vac_pkg::ST_LOAD, !(tag_s1.vld || tag_s2.vld))
	`VAC_ASSERT_SAME(a_result_into_empty, res_done, !out_vld_q)
	`VAC_ASSERT_SAME(a_read_in_range, tag_issue.vld, vac_pkg::CNT_W'(raddr_a) < (vac_pkg::CNT_W'(half_q) << 1))
	`VAC_ASSERT_NEXT(a_final_clears, in_acc && s_axis_tlast, cnt_q == '0 && !drop_q)

endmodule
